// ===== hw/rtl/sst_pkg.sv =====
package sst_pkg;

	localparam int SAMPLE_W = 32;
	localparam int INDEX_W  = 6;
	localparam int ECOUNT_W = 7;

	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_READ   = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_PARAM = 2'd1,
		ST_FULL      = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	typedef struct packed {
		logic                valid;
		logic                ge;
		logic [SAMPLE_W-1:0] value;
	} cell_link_t;

	function automatic logic [SAMPLE_W-1:0] sat_inc(input logic [SAMPLE_W-1:0] v);
		return (v == '1) ? v : v + SAMPLE_W'(1);
	endfunction

endpackage

// ===== hw/rtl/sst_in_if.sv =====
interface sst_in_if import sst_pkg::*;;
	logic                valid;
	logic                ready;
	logic                kind;
	logic [SAMPLE_W-1:0] sample_number;
	logic [INDEX_W-1:0]  read_index;

	modport source (output valid, kind, sample_number, read_index, input ready);
	modport sink   (input valid, kind, sample_number, read_index, output ready);
endinterface

// ===== hw/rtl/sst_out_if.sv =====
interface sst_out_if import sst_pkg::*;;
	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic [SAMPLE_W-1:0] read_value;
	logic [ECOUNT_W-1:0] entry_count;

	modport source (output valid, status, read_value, entry_count, input ready);
	modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

// ===== hw/rtl/sorted_sync_table_insert_top.sv =====
// An accepted item passes the stage register, then the output register, to rsp.
// Throughput: one item per cycle unless rsp stalls; all cells compare against
// the sample and cells past the insert point shift, as the result register drains.
// Reset: arst_n clears the entry count, all cell valid flags and the stage and
// output valids; entry values are not reset.
module sorted_sync_table_insert_top import sst_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	sst_in_if.sink     req,
	sst_out_if.source  rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	logic                valid_s1;
	logic                kind_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [INDEX_W-1:0]  index_s1;

	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_next;

	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [SAMPLE_W-1:0] read_value_q;
	logic [ECOUNT_W-1:0] entry_count_q;

	cell_link_t          links [DEPTH];
	logic [DEPTH-1:0]    last_eq_vec;

	logic                out_free;
	logic                done;
	logic                full;
	logic                last_eq_any;
	logic                commit;
	logic                read_hit;
	logic [SAMPLE_W-1:0] rd_value;
	status_t             status_c;
	logic [SAMPLE_W-1:0] value_c;

	assign out_free  = !out_valid_q || rsp.ready;
	assign done      = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			cell_link_t prev_link;
			logic       next_v;
			if (g == 0) begin : g_first
				assign prev_link = '0;
			end else begin : g_mid
				assign prev_link = links[g-1];
			end
			if (g == DEPTH - 1) begin : g_tail
				assign next_v = 1'b0;
			end else begin : g_body
				assign next_v = links[g+1].valid;
			end
			sst_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.prev       (prev_link),
				.next_valid (next_v),
				.sample     (sample_s1),
				.commit     (commit),
				.link       (links[g]),
				.last_eq    (last_eq_vec[g])
			);
		end
	endgenerate

	assign last_eq_any = |last_eq_vec;
	assign full        = (count_q == CW'(DEPTH));
	assign read_hit    = (32'(index_s1) < 32'(count_q));

	always_comb begin
		rd_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (32'(index_s1) == 32'(i)) begin
				rd_value = rd_value | links[i].value;
			end
		end
	end

	always_comb begin
		commit   = 1'b0;
		status_c = ST_OK;
		value_c  = '0;
		if (kind_s1 == KIND_READ) begin
			if (read_hit) begin
				value_c = rd_value;
			end else begin
				status_c = ST_BAD_INDEX;
			end
		end else if (sample_s1 == '0) begin
			status_c = ST_BAD_PARAM;
		end else if (last_eq_any) begin
			status_c = ST_OK;
		end else if (full) begin
			status_c = ST_FULL;
		end else begin
			commit = done;
		end
	end

	assign count_next = count_q + CW'(commit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
			count_q <= count_next;
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_s1   <= req.kind;
			sample_s1 <= req.sample_number;
			index_s1  <= req.read_index;
		end
		if (done) begin
			status_q      <= status_c;
			read_value_q  <= value_c;
			entry_count_q <= ECOUNT_W'(count_next);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.read_value  = read_value_q;
	assign rsp.entry_count = entry_count_q;

endmodule

// ===== hw/rtl/sst_cell.sv =====
module sst_cell import sst_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cell_link_t          prev,
	input  logic                next_valid,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                commit,
	output cell_link_t          link,
	output logic                last_eq
);

	logic                valid_q;
	logic [SAMPLE_W-1:0] value_q;
	logic                ge;
	logic                take_new;
	logic                take_shift;

	assign ge         = !valid_q || (value_q >= sample);
	assign take_new   = commit && ge && !prev.ge;
	assign take_shift = commit && prev.valid && prev.ge;
	assign link       = '{valid: valid_q, ge: ge, value: value_q};
	assign last_eq    = valid_q && !next_valid && (value_q == sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_new || take_shift) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_new) begin
			value_q <= sample;
		end else if (take_shift) begin
			value_q <= sat_inc(prev.value);
		end
	end

endmodule

// ===== hw/rtl/sst_checker.sv =====
module sst_checker import sst_pkg::*; #(
	parameter int DEPTH = 64
) (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [1:0]          rsp_status,
	input logic [SAMPLE_W-1:0] rsp_read_value,
	input logic [ECOUNT_W-1:0] rsp_entry_count
);

	localparam logic [ECOUNT_W-1:0] DEPTH_LO = ECOUNT_W'(DEPTH);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_read_value) && $stable(rsp_entry_count))
		else $error("rsp item changed while stalled");

	a_err_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_OK) |-> rsp_read_value == '0)
		else $error("nonzero read_value on error status");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_FULL) |-> rsp_entry_count == DEPTH_LO)
		else $error("table full reported below depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready ##1 rsp_valid && (rsp_status != ST_OK)
			|-> rsp_entry_count == $past(rsp_entry_count))
		else $error("entry count moved on a rejected item");

	a_req_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready
			&& $past(rsp_valid && !rsp_ready && req_valid && req_ready)
			|-> !req_ready)
		else $error("request accepted past a full pipeline");

endmodule

bind sorted_sync_table_insert_top sst_checker #(.DEPTH(DEPTH)) u_sst_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_read_value  (rsp.read_value),
	.rsp_entry_count (rsp.entry_count)
);
